// ===== hdl/rpvs_pkg.sv =====
package rpvs_pkg;

   localparam int DATA_W = 32;
   localparam int COEF_W = 31;
   localparam int CNT_W  = 6;

   localparam logic [1:0] CSR_TIME_STEP    = 2'd0;
   localparam logic [1:0] CSR_SPRING_COEFF = 2'd1;
   localparam logic [1:0] CSR_INV_MASS     = 2'd2;
   localparam logic [1:0] CSR_BEAD_COUNT   = 2'd3;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W+1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > $signed({{2{1'b0}}, SAT_MAX})) r = SAT_MAX;
      else if (x < $signed({{2{1'b1}}, SAT_MIN})) r = SAT_MIN;
      else r = x[DATA_W-1:0];
      return r;
   endfunction

endpackage

// ===== hdl/rpvs_qmul.sv =====
module rpvs_qmul
   import rpvs_pkg::*;
(
   input  logic                     clock,
   input  logic [COEF_W-1:0]        coef,
   input  logic signed [DATA_W-1:0] value,
   output logic signed [DATA_W-1:0] product
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [47:0] shifted;

   assign prod_in = $signed({1'b0, coef}) * value;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign shifted = prod_ff[63:16];

   always_comb begin
      if (shifted > 48'sh0000_7FFF_FFFF) product = SAT_MAX;
      else if (shifted < -48'sh0000_8000_0000) product = SAT_MIN;
      else product = shifted[DATA_W-1:0];
   end

endmodule

// ===== hdl/ring_polymer_verlet_step.sv =====
// One velocity Verlet step over a ring of beads, signed Q16.16. Beads are
// loaded one per start pulse (busy stays low). The pulse that completes
// the ring starts the step: three passes over the ring (half kick, drift,
// half kick) run on one shared registered multiplier, then the n updated
// beads are driven one per cycle with rsp_valid high; the receiver must
// take every result in its cycle. busy rises after the completing pulse
// and stays high until the last result cycle.
module ring_polymer_verlet_step
   import rpvs_pkg::*;
#(
   parameter int NBEAD = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_position,
   input  logic signed [DATA_W-1:0] req_momentum,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_new_position,
   output logic signed [DATA_W-1:0] rsp_new_momentum,
   output logic                     rsp_ring_end,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [COEF_W-1:0]        csr_data
);

   localparam int IDX_W = (NBEAD > 1) ? $clog2(NBEAD) : 1;
   localparam int NUM_W = $clog2(NBEAD + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_FRC0  = 10'b0000000010,
      S_FRC1  = 10'b0000000100,
      S_FRC2  = 10'b0000001000,
      S_FRC3  = 10'b0000010000,
      S_FRC4  = 10'b0000100000,
      S_POS0  = 10'b0001000000,
      S_POS1  = 10'b0010000000,
      S_POS2  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   logic [COEF_W-1:0] time_step_ff, spring_ff, inv_mass_ff;
   logic [CNT_W-1:0]  bead_count_ff;
   state_type         state_ff, state_in;
   logic [NUM_W-1:0]  load_ff, load_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic              pass2_ff, pass2_in;
   logic [NUM_W-1:0]  n_eff;

   logic signed [DATA_W-1:0] pos_mem [NBEAD];
   logic signed [DATA_W-1:0] mom_mem [NBEAD];
   logic signed [DATA_W-1:0] ph_mem  [NBEAD];

   logic signed [DATA_W-1:0] qc_ff, ql_ff, qr_ff, acc_ff;
   logic [COEF_W-1:0]        mcoef;
   logic signed [DATA_W-1:0] mval, mres;
   logic [IDX_W-1:0]         last_idx, jl, jr;

   rpvs_qmul u_mul (.clock(clock), .coef(mcoef), .value(mval), .product(mres));

   always_comb begin
      if (bead_count_ff == '0) n_eff = NUM_W'(1);
      else if ({1'b0, bead_count_ff} > 7'(NBEAD)) n_eff = NUM_W'(NBEAD);
      else n_eff = NUM_W'(bead_count_ff);
      last_idx = IDX_W'(n_eff - NUM_W'(1));
      jl = (j_ff == '0) ? last_idx : j_ff - IDX_W'(1);
      jr = (j_ff == last_idx) ? '0 : j_ff + IDX_W'(1);
   end

   logic signed [DATA_W+1:0] lap_w;
   logic signed [DATA_W-1:0] lap, frc;
   logic signed [DATA_W-1:0] ph_next;
   logic                     accept;

   assign lap_w = ($signed({{2{qc_ff[DATA_W-1]}}, qc_ff}) <<< 1)
                - {{2{ql_ff[DATA_W-1]}}, ql_ff} - {{2{qr_ff[DATA_W-1]}}, qr_ff};
   assign lap = sat_sum(lap_w);
   assign frc = sat_sum(-{{2{acc_ff[DATA_W-1]}}, acc_ff} - {{2{qc_ff[DATA_W-1]}}, qc_ff});
   assign ph_next = sat_sum({{2{mom_mem[j_ff][DATA_W-1]}}, mom_mem[j_ff]}
                          + {{2{mres[DATA_W-1]}}, mres});
   assign accept = start && !busy;

   always_comb begin
      mcoef = spring_ff;
      mval  = lap;
      case (state_ff)
         S_FRC3: begin mcoef = {1'b0, time_step_ff[COEF_W-1:1]}; mval = frc; end
         S_POS0: begin mcoef = time_step_ff; mval = acc_ff; end
         S_POS1: begin mcoef = inv_mass_ff; mval = mres; end
         default: begin mcoef = spring_ff; mval = lap; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      load_in  = load_ff;
      j_in     = j_ff;
      pass2_in = pass2_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (NUM_W'(load_ff + NUM_W'(1)) >= n_eff) begin
                  load_in  = '0;
                  j_in     = '0;
                  pass2_in = 1'b0;
                  state_in = S_FRC0;
               end else begin
                  load_in = load_ff + NUM_W'(1);
               end
            end
         end
         S_FRC0: state_in = S_FRC1;
         S_FRC1: state_in = S_FRC2;
         S_FRC2: state_in = S_FRC3;
         S_FRC3: state_in = S_FRC4;
         S_FRC4: begin
            if (j_ff == last_idx) begin
               j_in     = '0;
               state_in = pass2_ff ? S_OUT : S_POS0;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = S_FRC0;
            end
         end
         S_POS0: state_in = S_POS1;
         S_POS1: state_in = S_POS2;
         S_POS2: begin
            if (j_ff == last_idx) begin
               j_in     = '0;
               pass2_in = 1'b1;
               state_in = S_FRC0;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = S_POS0;
            end
         end
         S_OUT: begin
            if (j_ff == last_idx) begin
               j_in     = '0;
               state_in = S_IDLE;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         load_ff       <= '0;
         j_ff          <= '0;
         pass2_ff      <= 1'b0;
         time_step_ff  <= 31'd3277;
         spring_ff     <= 31'd65536;
         inv_mass_ff   <= 31'd65536;
         bead_count_ff <= 6'd32;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         j_ff     <= j_in;
         pass2_ff <= pass2_in;
         if (csr_write) begin
            case (csr_index)
               CSR_TIME_STEP:    time_step_ff  <= csr_data;
               CSR_SPRING_COEFF: spring_ff     <= csr_data;
               CSR_INV_MASS:     inv_mass_ff   <= csr_data;
               CSR_BEAD_COUNT:   bead_count_ff <= csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath and stores
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_mem[IDX_W'(load_ff)] <= req_position;
               mom_mem[IDX_W'(load_ff)] <= req_momentum;
            end
         end
         S_FRC0: begin
            qc_ff <= pos_mem[j_ff];
            ql_ff <= pos_mem[jl];
            qr_ff <= pos_mem[jr];
         end
         S_FRC2: acc_ff <= mres;
         S_FRC4: begin
            if (pass2_ff)
               mom_mem[j_ff] <= sat_sum({{2{ph_mem[j_ff][DATA_W-1]}}, ph_mem[j_ff]}
                                      + {{2{mres[DATA_W-1]}}, mres});
            else
               ph_mem[j_ff] <= ph_next;
         end
         S_POS2: pos_mem[j_ff] <= sat_sum({{2{pos_mem[j_ff][DATA_W-1]}}, pos_mem[j_ff]}
                                        + {{2{mres[DATA_W-1]}}, mres});
         default: ;
      endcase
      if (state_ff == S_FRC4 && j_ff == last_idx && !pass2_ff)
         acc_ff <= (j_ff == '0) ? ph_next : ph_mem[0];
      else if (state_ff == S_POS2) acc_ff <= ph_mem[jr];
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_new_position = pos_mem[j_ff];
   assign rsp_new_momentum = mom_mem[j_ff];
   assign rsp_ring_end     = (state_ff == S_OUT) && (j_ff == last_idx);

endmodule

// ===== sim/ring_polymer_verlet_step_tb.sv =====
`timescale 1ns / 1ps

module ring_polymer_verlet_step_tb;
   import rpvs_pkg::*;

   localparam int NBEAD      = 32;
   localparam int SETTLE     = 600;
   localparam int CYCLE_MAX  = 400000;

   typedef struct {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] momentum;
   } bead_type;

   typedef struct {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] momentum;
      logic                     ring_end;
   } bead_update_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [DATA_W-1:0] req_position = '0;
   logic signed [DATA_W-1:0] req_momentum = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_new_position;
   logic signed [DATA_W-1:0] rsp_new_momentum;
   logic                     rsp_ring_end;
   logic                     csr_write = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [COEF_W-1:0]        csr_data = '0;

   bead_type        bead_queue[$];
   bead_update_type update_queue[$];
   bead_type        cur_bead;
   int              gap_left = 0;
   int              mismatches = 0;
   int              cycles = 0;

   longint unsigned ts_q, spring_q, inv_mass_q, beads_q;
   int              pos_mem[NBEAD];
   int              mom_mem[NBEAD];
   int              beads_loaded;

   ring_polymer_verlet_step #(.NBEAD(NBEAD)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_position(req_position), .req_momentum(req_momentum),
      .rsp_valid(rsp_valid), .rsp_new_position(rsp_new_position),
      .rsp_new_momentum(rsp_new_momentum), .rsp_ring_end(rsp_ring_end),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic int sat32(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return int'(x);
   endfunction

   function automatic int qmul(longint unsigned coeff, int v);
      longint p;
      p = longint'(coeff) * longint'(v);
      return sat32(p >>> 16);
   endfunction

   function automatic int bead_force(int n, int j);
      int left, right, lap, spring;
      left  = (j == 0) ? n - 1 : j - 1;
      right = (j + 1 >= n) ? 0 : j + 1;
      lap = sat32(2 * longint'(pos_mem[j]) - longint'(pos_mem[left])
                  - longint'(pos_mem[right]));
      spring = qmul(spring_q, lap);
      return sat32(-longint'(spring) - longint'(pos_mem[j]));
   endfunction

   task automatic verlet_load(bead_type b);
      int n, j, step;
      longint unsigned half;
      int p_half[NBEAD];
      bead_update_type u;
      n = int'(beads_q);
      if (n == 0) n = 1;
      if (n > NBEAD) n = NBEAD;
      half = ts_q >> 1;
      if (beads_loaded >= NBEAD) beads_loaded = 0;
      pos_mem[beads_loaded] = b.position;
      mom_mem[beads_loaded] = b.momentum;
      beads_loaded++;
      if (beads_loaded < n) return;
      beads_loaded = 0;
      for (j = 0; j < n; j++)
         p_half[j] = sat32(longint'(mom_mem[j]) + qmul(half, bead_force(n, j)));
      for (j = 0; j < n; j++) begin
         step = qmul(inv_mass_q, qmul(ts_q, p_half[j]));
         pos_mem[j] = sat32(longint'(pos_mem[j]) + longint'(step));
      end
      for (j = 0; j < n; j++)
         mom_mem[j] = sat32(longint'(p_half[j]) + qmul(half, bead_force(n, j)));
      for (j = 0; j < n; j++) begin
         u.position = pos_mem[j];
         u.momentum = mom_mem[j];
         u.ring_end = (j + 1 == n);
         update_queue = {update_queue, u};
      end
   endtask

   function automatic int draw_gap();
      return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 12) : 0;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) verlet_load(cur_bead);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (bead_queue.size() != 0) begin
               cur_bead = bead_queue.pop_front();
               req_position <= cur_bead.position;
               req_momentum <= cur_bead.momentum;
               start <= 1'b1;
               gap_left <= draw_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bead_update_type e;
      if (!reset && rsp_valid) begin
         if (update_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result pos=%h mom=%h end=%b",
                                           rsp_new_position, rsp_new_momentum, rsp_ring_end);
         end else begin
            e = update_queue.pop_front();
            if (e.position !== rsp_new_position || e.momentum !== rsp_new_momentum ||
                e.ring_end !== rsp_ring_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp pos=%h mom=%h end=%b got pos=%h mom=%h end=%b",
                           e.position, e.momentum, e.ring_end,
                           rsp_new_position, rsp_new_momentum, rsp_ring_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_put(logic [1:0] idx, logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_TIME_STEP:    ts_q = 64'(value);
         CSR_SPRING_COEFF: spring_q = 64'(value);
         CSR_INV_MASS:     inv_mass_q = 64'(value);
         CSR_BEAD_COUNT:   beads_q = 64'(value & 31'h3F);
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      while (bead_queue.size() != 0 || start || gap_left != 0 || update_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic configure(logic [COEF_W-1:0] ts, logic [COEF_W-1:0] sc,
                            logic [COEF_W-1:0] im, logic [COEF_W-1:0] bc);
      wait_drain();
      csr_put(CSR_TIME_STEP, ts);
      csr_put(CSR_SPRING_COEFF, sc);
      csr_put(CSR_INV_MASS, im);
      csr_put(CSR_BEAD_COUNT, bc);
   endtask

   function automatic logic signed [DATA_W-1:0] draw_word();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         4:          return $urandom();
         5:          return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
         default:    return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   task automatic push_bead(logic signed [DATA_W-1:0] p, logic signed [DATA_W-1:0] m);
      bead_type b;
      b.position = p;
      b.momentum = m;
      bead_queue = {bead_queue, b};
   endtask

   task automatic push_random(int count);
      repeat (count) push_bead(draw_word(), draw_word());
   endtask

   function automatic logic [COEF_W-1:0] draw_coeff(logic [COEF_W-1:0] typical);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return {COEF_W{1'b1}};
         2:       return COEF_W'($urandom());
         default: return COEF_W'($urandom_range(0, 32'(typical)));
      endcase
   endfunction

   initial begin
      ts_q = 3277;
      spring_q = 65536;
      inv_mass_q = 65536;
      beads_q = 32;
      beads_loaded = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single bead, field extremes
      configure(31'd3277, 31'd65536, 31'd65536, 31'd1);
      push_bead(SAT_MAX, SAT_MAX);
      push_bead(SAT_MIN, SAT_MIN);
      push_bead('0, '0);
      push_bead(-32'sd1, 32'sd1);
      // two beads
      configure(31'd6554, 31'd131072, 31'd32768, 31'd2);
      push_bead(SAT_MAX, SAT_MIN);
      push_bead(SAT_MIN, SAT_MAX);
      push_bead(32'sh0001_0000, -32'sh0001_0000);
      push_bead(-32'sh0001_0000, 32'sh0000_8000);
      // zero count acts as one, coefficients at maximum
      configure({COEF_W{1'b1}}, {COEF_W{1'b1}}, {COEF_W{1'b1}}, 31'h7FFF_FFC0);
      push_bead(32'sh0000_0100, -32'sh0000_0100);
      push_bead(SAT_MIN, '0);
      // oversize count acts as a full ring, coefficients at zero
      configure('0, '0, '0, 31'd63);
      push_random(NBEAD);
      // lower the count mid-ring
      configure(31'd3277, 31'd65536, 31'd65536, 31'd8);
      push_random(5);
      configure(31'd3277, 31'd65536, 31'd65536, 31'd3);
      push_random(4);

      repeat (12) begin
         configure(draw_coeff(31'd20000), draw_coeff(31'd200000), draw_coeff(31'd200000),
                   ($urandom_range(0, 4) == 0) ? 31'd32 : COEF_W'($urandom_range(1, 8)));
         push_random(20);
      end

      wait_drain();
      if (mismatches == 0 && update_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
